### design/lep_pkg.sv
package lep_pkg;

	// Register indexes of the configuration port.
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_GREY  = 2'd0;
	localparam cfg_idx_t CFG_BLACK = 2'd1;
	localparam cfg_idx_t CFG_RANGE = 2'd2;

	// Reset values of the registers.
	localparam logic [14:0] GREY_RESET  = 15'd4608;
	localparam logic [13:0] BLACK_RESET = 14'h3B00;
	localparam logic [13:0] RANGE_RESET = 14'd2560;

	// Grey level is percent in Q7.8, so the sample is scaled by 100 * 256.
	localparam logic [14:0] GREY_SCALE = 15'd25600;

	// Stage counts of the pipeline sections.
	localparam int QDIV_STAGES = 24;
	localparam int LOG_STAGES  = 16;
	localparam int RDIV_STAGES = 15;
	localparam int NUM_STAGES  = 1 + QDIV_STAGES + 2 + LOG_STAGES + 1 + RDIV_STAGES + 1;

	// One restoring division step: returns {new remainder, quotient bit}.
	function automatic logic [16:0] div_step(input logic [15:0] rem, input logic nb,
			input logic [15:0] d);
		logic [16:0] r2;
		logic        qb;
		r2 = {rem, nb};
		qb = (r2 >= {1'b0, d});
		if (qb) begin
			r2 = r2 - {1'b0, d};
		end
		return {r2[15:0], qb};
	endfunction

endpackage

### design/log_exposure_encoder.sv
// Log exposure encoder: Q16.16 scene-linear sample to Q16.16 log2 code.
// A request passes through 60 pipeline stages before its result is valid.
// Throughput is one request per cycle while the output is not stalled; the pipeline is set by a radix-4 divider
// for the grey normalization, 16 squaring multipliers and a radix-4 range divider.
// The asynchronous reset clears the valid bits and loads the register defaults.
module log_exposure_encoder import lep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] linear_sample,
	input  logic        frame_end_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] encoded_sample,
	output logic        frame_end_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cfg_idx_t    cfg_index,
	input  logic [14:0] cfg_data
);

	logic [14:0]        grey_q;
	logic signed [13:0] black_q;
	logic [13:0]        range_q;
	logic [15:0]        grey_div;
	logic [15:0]        range_div;
	logic               adv;

	logic [NUM_STAGES-1:0] vld_s;
	logic [NUM_STAGES-1:0] fe_s;

	logic [47:0] num_s1;

	logic [47:0] qd_num_s [QDIV_STAGES];
	logic [15:0] qd_rem_s [QDIV_STAGES];
	logic [47:0] qd_quo_s [QDIV_STAGES];

	logic [47:0] qc_lz;
	logic [5:0]  e_lz;
	logic [47:0] qc_slz;
	logic [5:0]  e_slz;
	logic [31:0] m_snm;
	logic [5:0]  e_snm;

	logic [31:0] lg_m_s [LOG_STAGES];
	logic [15:0] lg_f_s [LOG_STAGES];
	logic [5:0]  lg_e_s [LOG_STAGES];

	logic [21:0] tp_st;
	logic        pos_st;

	logic [29:0] rd_num_s [RDIV_STAGES];
	logic [15:0] rd_rem_s [RDIV_STAGES];
	logic [29:0] rd_quo_s [RDIV_STAGES];
	logic        rd_pos_s [RDIV_STAGES];

	logic [31:0] enc_sout;

	// Configuration writes; unknown indexes are ignored.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grey_q  <= GREY_RESET;
			black_q <= BLACK_RESET;
			range_q <= RANGE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GREY:  grey_q  <= cfg_data;
				CFG_BLACK: black_q <= cfg_data[13:0];
				CFG_RANGE: range_q <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// A zero divisor is treated as one.
	assign grey_div  = (grey_q == '0) ? 16'd1 : {1'b0, grey_q};
	assign range_div = (range_q == '0) ? 16'd1 : {2'b0, range_q};

	// The whole pipeline moves unless the result stage holds a stalled request.
	assign adv       = !vld_s[NUM_STAGES-1] || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = vld_s[NUM_STAGES-1];
	assign frame_end_out  = fe_s[NUM_STAGES-1];
	assign encoded_sample = enc_sout;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NUM_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fe_s   <= {fe_s[NUM_STAGES-2:0], frame_end_in};
			num_s1 <= 48'(linear_sample) * 48'(GREY_SCALE);
		end
	end

	// Grey normalization divider, two quotient bits per stage.
	for (genvar j = 0; j < QDIV_STAGES; j++) begin : g_qdiv
		logic [47:0] num_in;
		logic [15:0] rem_in;
		logic [47:0] quo_in;
		logic [16:0] st_a;
		logic [16:0] st_b;
		if (j == 0) begin : g_first
			assign num_in = num_s1;
			assign rem_in = '0;
			assign quo_in = '0;
		end else begin : g_next
			assign num_in = qd_num_s[j-1];
			assign rem_in = qd_rem_s[j-1];
			assign quo_in = qd_quo_s[j-1];
		end
		assign st_a = div_step(rem_in, num_in[47], grey_div);
		assign st_b = div_step(st_a[16:1], num_in[46], grey_div);
		always_ff @(posedge clk) begin
			if (adv) begin
				qd_num_s[j] <= {num_in[45:0], 2'b00};
				qd_rem_s[j] <= st_b[16:1];
				qd_quo_s[j] <= {quo_in[45:0], st_a[0], st_b[0]};
			end
		end
	end

	// Floor the quotient and find its top set bit.
	always_comb begin
		qc_lz = (qd_quo_s[QDIV_STAGES-1] == '0) ? 48'd1 : qd_quo_s[QDIV_STAGES-1];
		e_lz  = '0;
		for (int i = 0; i < 48; i++) begin
			if (qc_lz[i]) begin
				e_lz = 6'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qc_slz <= qc_lz;
			e_slz  <= e_lz;
		end
	end

	// Normalize the mantissa to 1.31.
	always_ff @(posedge clk) begin
		logic [47:0] qn;
		qn = qc_slz << (6'd47 - e_slz);
		if (adv) begin
			m_snm <= qn[47:16];
			e_snm <= e_slz;
		end
	end

	// Fraction bits by repeated squaring, one bit per stage.
	for (genvar k = 0; k < LOG_STAGES; k++) begin : g_log
		logic [31:0] m_in;
		logic [15:0] f_in;
		logic [5:0]  e_in;
		logic [63:0] sq;
		logic [32:0] m2;
		if (k == 0) begin : g_first
			assign m_in = m_snm;
			assign f_in = '0;
			assign e_in = e_snm;
		end else begin : g_next
			assign m_in = lg_m_s[k-1];
			assign f_in = lg_f_s[k-1];
			assign e_in = lg_e_s[k-1];
		end
		assign sq = 64'(m_in) * 64'(m_in);
		assign m2 = sq[63:31];
		always_ff @(posedge clk) begin
			if (adv) begin
				lg_m_s[k] <= m2[32] ? m2[32:1] : m2[31:0];
				lg_f_s[k] <= {f_in[14:0], m2[32]};
				lg_e_s[k] <= e_in;
			end
		end
	end

	// Subtract the black exposure from the log value.
	always_ff @(posedge clk) begin
		logic signed [23:0] lv;
		logic signed [23:0] bv;
		logic signed [23:0] t;
		lv = $signed({8'(lg_e_s[LOG_STAGES-1]) - 8'd16, lg_f_s[LOG_STAGES-1]});
		bv = $signed({{2{black_q[13]}}, black_q, 8'b0});
		t  = lv - bv;
		if (adv) begin
			pos_st <= !t[23] && (t != '0);
			tp_st  <= t[21:0];
		end
	end

	// Range divider, two quotient bits per stage.
	for (genvar j = 0; j < RDIV_STAGES; j++) begin : g_rdiv
		logic [29:0] num_in;
		logic [15:0] rem_in;
		logic [29:0] quo_in;
		logic        pos_in;
		logic [16:0] st_a;
		logic [16:0] st_b;
		if (j == 0) begin : g_first
			assign num_in = {tp_st, 8'b0};
			assign rem_in = '0;
			assign quo_in = '0;
			assign pos_in = pos_st;
		end else begin : g_next
			assign num_in = rd_num_s[j-1];
			assign rem_in = rd_rem_s[j-1];
			assign quo_in = rd_quo_s[j-1];
			assign pos_in = rd_pos_s[j-1];
		end
		assign st_a = div_step(rem_in, num_in[29], range_div);
		assign st_b = div_step(st_a[16:1], num_in[28], range_div);
		always_ff @(posedge clk) begin
			if (adv) begin
				rd_num_s[j] <= {num_in[27:0], 2'b00};
				rd_rem_s[j] <= st_b[16:1];
				rd_quo_s[j] <= {quo_in[27:0], st_a[0], st_b[0]};
				rd_pos_s[j] <= pos_in;
			end
		end
	end

	// Apply the noise floor and register the result.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (!rd_pos_s[RDIV_STAGES-1] || rd_quo_s[RDIV_STAGES-1] == '0) begin
				enc_sout <= 32'd1;
			end else begin
				enc_sout <= {2'b00, rd_quo_s[RDIV_STAGES-1]};
			end
		end
	end

endmodule
